// ----- rtl/keypad_scan_seven_segment_display_assert.svh -----
// ----------------------------------------------------------------------------
// keypad_scan_seven_segment_display_assert.svh
// Assertion macros used by the checker file of the keypad/display block.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_SCAN_SEVEN_SEGMENT_DISPLAY_ASSERT_SVH
`define KEYPAD_SCAN_SEVEN_SEGMENT_DISPLAY_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define KSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define KSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/kss_pkg.sv -----
// ----------------------------------------------------------------------------
// kss_pkg
// Types, codes and the segment table of the keypad scanner and display.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int NUM_DIGITS_DEF = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_TICKS = 1'b1;

    localparam logic [15:0] HOLD_TICKS_RST  = 16'd2000;
    localparam logic [7:0]  DIGIT_TICKS_RST = 8'd1;

    localparam logic [4:0] NO_KEY      = 5'd16;
    localparam logic [3:0] SEL_BLANK   = 4'hF;
    localparam logic [3:0] ROW0_DRIVE  = 4'hE;

    typedef struct packed {
        logic [3:0] column_bits;
    } t_in_item;

    typedef struct packed {
        logic [3:0] row_drive;
        logic [7:0] segments;
        logic [3:0] digit_select;
        logic [4:0] key_code;
        logic       key_event;
    } t_out_item;

    // Hex digits 0..F, anything else shows a dash.
    function automatic logic [7:0] glyph(input logic [4:0] code);
        logic [7:0] seg;
        unique case (code)
            5'd0:    seg = 8'hfc;
            5'd1:    seg = 8'h60;
            5'd2:    seg = 8'hda;
            5'd3:    seg = 8'hf2;
            5'd4:    seg = 8'h66;
            5'd5:    seg = 8'hb6;
            5'd6:    seg = 8'hbe;
            5'd7:    seg = 8'he0;
            5'd8:    seg = 8'hfe;
            5'd9:    seg = 8'hf6;
            5'd10:   seg = 8'hee;
            5'd11:   seg = 8'h3e;
            5'd12:   seg = 8'h9c;
            5'd13:   seg = 8'h7a;
            5'd14:   seg = 8'h9e;
            5'd15:   seg = 8'h8e;
            default: seg = 8'h02;
        endcase
        return seg;
    endfunction

endpackage

// ----- rtl/kss_in_if.sv -----
// ----------------------------------------------------------------------------
// kss_in_if
// Column sample channel: valid, ready and one column sample per beat.
// ----------------------------------------------------------------------------
interface kss_in_if;
    import kss_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/kss_out_if.sv -----
// ----------------------------------------------------------------------------
// kss_out_if
// Result channel: valid, ready and one row/segment/key result per beat.
// ----------------------------------------------------------------------------
interface kss_out_if;
    import kss_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/keypad_scan_seven_segment_display.sv -----
// ----------------------------------------------------------------------------
// keypad_scan_seven_segment_display
// Tick-driven 4x4 keypad scanner and multiplexed seven-segment display.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one beat per tick: the active-low column lines sampled while
//   the row last shown on row_drive was driven. o_out returns exactly one beat
//   for every input beat: next row drive, segment and digit-select lines, and
//   the key code with its event flag on the tick that a scan round ends.
//   The result of a beat is registered and valid after the edge that accepts
//   it. One beat per cycle is sustained while the receiver takes each beat;
//   the state update is a single pass of counter compares and a 17-entry
//   glyph lookup between the state registers and the result register.
//   When the receiver stalls, the result register holds its beat and i_in
//   ready drops until it is taken; a new beat is taken in the same cycle the
//   held one leaves.
//   Reset (synchronous, active low) starts a scan at row 0, fills the digit
//   store with dashes, blanks the digit selects and loads the register
//   defaults (hold 2000 ticks, 1 tick per digit). Config writes are taken
//   on any cycle with i_cfg_we high.
// ----------------------------------------------------------------------------
module keypad_scan_seven_segment_display #(
    parameter int NUM_DIGITS = kss_pkg::NUM_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    kss_in_if.sink                          i_in,
    kss_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [kss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kss_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import kss_pkg::*;

    localparam int DW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    localparam logic [1:0] PH_SCAN = 2'd0;
    localparam logic [1:0] PH_HOLD = 2'd1;
    localparam logic [1:0] PH_SHOW = 2'd2;

    logic [15:0]   r_hold_ticks;
    logic [7:0]    r_digit_ticks;

    logic [1:0]    r_phase,         n_phase;
    logic [1:0]    r_row_index,     n_row_index;
    logic [DW-1:0] r_display_index, n_display_index;
    logic [4:0]    r_pending_key,   n_pending_key;
    logic [4:0]    r_digit_store [NUM_DIGITS];
    logic [4:0]    n_digit_store [NUM_DIGITS];
    logic [15:0]   r_tick_count,    n_tick_count;
    logic [7:0]    r_segment_latch, n_segment_latch;
    logic [3:0]    r_select_latch,  n_select_latch;

    logic [4:0]    n_key_code;
    logic          n_key_event;

    t_out_item     r_out;
    logic          r_out_valid;
    t_out_item     n_out;

    logic          in_accept;
    logic [15:0]   tick_inc;
    logic [DW:0]   disp_inc;
    logic [7:0]    digit_limit;
    logic [4:0]    show_code;
    logic [2:0]    disp_idx3;
    logic          col_hit;
    logic [1:0]    col_num;
    logic [4:0]    scan_key;

    assign in_accept   = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign tick_inc    = r_tick_count + 16'd1;
    assign disp_inc    = {1'b0, r_display_index} + {{DW{1'b0}}, 1'b1};
    assign digit_limit = (r_digit_ticks == 8'd0) ? 8'd1 : r_digit_ticks;
    assign disp_idx3   = 3'(r_display_index);

    // Only a single low column names a key.
    always_comb begin
        col_hit = 1'b1;
        col_num = 2'd0;
        unique case (i_in.data.column_bits)
            4'hE:    col_num = 2'd0;
            4'hD:    col_num = 2'd1;
            4'hB:    col_num = 2'd2;
            4'h7:    col_num = 2'd3;
            default: col_hit = 1'b0;
        endcase
    end

    always_comb begin
        scan_key = r_pending_key;
        if (col_hit) begin
            scan_key = {1'b0, r_row_index, col_num};
        end
        show_code = r_digit_store[r_display_index];
        if (show_code > NO_KEY) begin
            show_code = NO_KEY;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_row_index     = r_row_index;
        n_display_index = r_display_index;
        n_pending_key   = r_pending_key;
        n_digit_store   = r_digit_store;
        n_tick_count    = r_tick_count;
        n_segment_latch = r_segment_latch;
        n_select_latch  = r_select_latch;
        n_key_code      = NO_KEY;
        n_key_event     = 1'b0;

        unique case (r_phase)
            PH_HOLD: begin
                n_tick_count = tick_inc;
                if (tick_inc >= r_hold_ticks) begin
                    n_tick_count    = 16'd0;
                    n_display_index = '0;
                    n_phase         = PH_SHOW;
                end
            end
            PH_SHOW: begin
                n_segment_latch = glyph(show_code);
                n_select_latch  = disp_idx3[2] ? SEL_BLANK
                                               : ~(4'b0001 << disp_idx3[1:0]);
                n_tick_count    = tick_inc;
                if (tick_inc >= {8'd0, digit_limit}) begin
                    n_tick_count = 16'd0;
                    // advance to the next digit, back to scanning after the last
                    if (disp_inc >= (DW+1)'(NUM_DIGITS)) begin
                        n_display_index = '0;
                        n_row_index     = 2'd0;
                        n_pending_key   = NO_KEY;
                        n_phase         = PH_SCAN;
                    end else begin
                        n_display_index = disp_inc[DW-1:0];
                    end
                end
            end
            default: begin
                if (r_row_index == 2'd3) begin
                    n_row_index     = 2'd0;
                    n_tick_count    = 16'd0;
                    n_display_index = '0;
                    n_pending_key   = NO_KEY;
                    if (!scan_key[4]) begin
                        for (int i = NUM_DIGITS - 1; i > 0; i--) begin
                            n_digit_store[i] = r_digit_store[i-1];
                        end
                        n_digit_store[0] = scan_key;
                        n_key_code       = scan_key;
                        n_key_event      = 1'b1;
                        n_phase = (r_hold_ticks == 16'd0) ? PH_SHOW : PH_HOLD;
                    end else begin
                        n_phase = PH_SHOW;
                    end
                end else begin
                    n_row_index   = r_row_index + 2'd1;
                    n_pending_key = scan_key;
                end
            end
        endcase

        n_out.row_drive    = ~(4'b0001 << n_row_index);
        n_out.segments     = n_segment_latch;
        n_out.digit_select = n_select_latch;
        n_out.key_code     = n_key_code;
        n_out.key_event    = n_key_event;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks  <= HOLD_TICKS_RST;
            r_digit_ticks <= DIGIT_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HOLD_TICKS:  r_hold_ticks  <= i_cfg_data;
                REG_DIGIT_TICKS: r_digit_ticks <= i_cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_SCAN;
            r_row_index     <= 2'd0;
            r_display_index <= '0;
            r_pending_key   <= NO_KEY;
            r_tick_count    <= 16'd0;
            r_segment_latch <= 8'd0;
            r_select_latch  <= SEL_BLANK;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_digit_store[i] <= NO_KEY;
            end
        end else if (in_accept) begin
            r_phase         <= n_phase;
            r_row_index     <= n_row_index;
            r_display_index <= n_display_index;
            r_pending_key   <= n_pending_key;
            r_tick_count    <= n_tick_count;
            r_segment_latch <= n_segment_latch;
            r_select_latch  <= n_select_latch;
            r_digit_store   <= n_digit_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result beat until it is taken
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/kss_checker.sv -----
// ----------------------------------------------------------------------------
// kss_checker
// Port-level checks of the keypad scanner result channel.
// ----------------------------------------------------------------------------
`include "keypad_scan_seven_segment_display_assert.svh"

module kss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_row_drive,
    input logic [7:0] i_segments,
    input logic [3:0] i_digit_select,
    input logic [4:0] i_key_code,
    input logic       i_key_event
);
    import kss_pkg::*;

    // a stalled beat keeps its payload
    `KSS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, $stable({i_row_drive, i_segments, i_digit_select, i_key_code, i_key_event}), "stalled result beat changed")

    // exactly one row is driven low
    `KSS_ASSERT_NOW(a_row_onehot, i_out_valid, $onehot(~i_row_drive), "row drive not one-hot low")

    // a key event carries a real key, no event carries the no-key code
    `KSS_ASSERT_NOW(a_key_code, i_out_valid, i_key_event == (i_key_code != NO_KEY), "key code and event disagree")

    // a key ends a scan round, so the next sample is row 0
    `KSS_ASSERT_NOW(a_key_row0, i_out_valid && i_key_event, i_row_drive == ROW0_DRIVE, "key event without row 0 drive")

    // digit selects are blanked or light a single digit
    `KSS_ASSERT_NOW(a_sel_onehot, i_out_valid, (i_digit_select == SEL_BLANK) || $onehot(~i_digit_select), "more than one digit selected")

endmodule

bind keypad_scan_seven_segment_display kss_checker u_kss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_row_drive    (o_out.data.row_drive),
    .i_segments     (o_out.data.segments),
    .i_digit_select (o_out.data.digit_select),
    .i_key_code     (o_out.data.key_code),
    .i_key_event    (o_out.data.key_event)
);

// ----- tb/tb_keypad_scan_seven_segment_display.sv -----
// ----------------------------------------------------------------------------
// tb_keypad_scan_seven_segment_display
// Drives column samples that follow the row the block drives. The samples
// come from held keys, two-key presses, releases and raw noise. The block's
// sequencer (scan, hold, digit display) is tracked beat by beat, and every
// result beat is compared field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_keypad_scan_seven_segment_display;
    timeunit 1ns;
    timeprecision 1ps;

    import kss_pkg::*;

    localparam int DIGITS       = NUM_DIGITS_DEF;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PRESSURE_AT  = 500;
    localparam int PRESSURE_LEN = 60;

    typedef enum logic [1:0] {SEQ_SCAN, SEQ_HOLD, SEQ_SHOW} t_seq_phase;

    // One column beat: keys held on the pad, or a raw column pattern.
    typedef struct {
        logic [4:0] key_a;
        logic [4:0] key_b;
        bit         raw;
        logic [3:0] bits;
    } t_pad_beat;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kss_in_if  in_if ();
    kss_out_if out_if ();

    keypad_scan_seven_segment_display DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Sequencer state tracked by the testbench.
    logic [15:0] hold_cfg;
    logic [7:0]  digit_cfg;
    t_seq_phase  sq_phase;
    logic [1:0]  sq_row;
    int          sq_disp;
    logic [4:0]  sq_pending;
    logic [4:0]  sq_store [DIGITS];
    logic [15:0] sq_tick;
    logic [7:0]  sq_seg;
    logic [3:0]  sq_sel;

    t_pad_beat pad_queue [$];
    t_out_item expected_beats [$];

    int scan_beats;
    int beats_in;
    int results;
    int key_events;
    int mismatches;
    int idle_cycles;
    int send_gap;
    int hold_off;
    bit fast;
    bit steady_in;
    bit steady_out;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] digit_glyph(input logic [4:0] code);
        case (code)
            5'd0:    return 8'hfc;
            5'd1:    return 8'h60;
            5'd2:    return 8'hda;
            5'd3:    return 8'hf2;
            5'd4:    return 8'h66;
            5'd5:    return 8'hb6;
            5'd6:    return 8'hbe;
            5'd7:    return 8'he0;
            5'd8:    return 8'hfe;
            5'd9:    return 8'hf6;
            5'd10:   return 8'hee;
            5'd11:   return 8'h3e;
            5'd12:   return 8'h9c;
            5'd13:   return 8'h7a;
            5'd14:   return 8'h9e;
            5'd15:   return 8'h8e;
            default: return 8'h02;
        endcase
    endfunction

    // Advance the tracked sequencer by one tick and return the result beat.
    function automatic t_out_item advance_sequencer(input logic [3:0] cols);
        t_out_item  res;
        logic [4:0] key;
        logic [4:0] code;
        logic [15:0] limit;
        int         col;
        int         i;
        key = NO_KEY;
        res.key_event = 1'b0;
        case (sq_phase)
            SEQ_HOLD: begin
                sq_tick++;
                if (sq_tick >= hold_cfg) begin
                    sq_tick  = '0;
                    sq_disp  = 0;
                    sq_phase = SEQ_SHOW;
                end
            end
            SEQ_SHOW: begin
                code   = sq_store[sq_disp % DIGITS];
                limit  = (digit_cfg == 8'd0) ? 16'd1 : 16'(digit_cfg);
                sq_seg = digit_glyph(code);
                sq_sel = (sq_disp < 4) ? ~(4'b0001 << sq_disp) : SEL_BLANK;
                sq_tick++;
                if (sq_tick >= limit) begin
                    sq_tick = '0;
                    sq_disp++;
                    if (sq_disp >= DIGITS) begin
                        sq_disp    = 0;
                        sq_row     = 2'd0;
                        sq_pending = NO_KEY;
                        sq_phase   = SEQ_SCAN;
                    end
                end
            end
            default: begin
                case (cols)
                    4'hE:    col = 0;
                    4'hD:    col = 1;
                    4'hB:    col = 2;
                    4'h7:    col = 3;
                    default: col = -1;
                endcase
                if (col >= 0)
                    sq_pending = {1'b0, sq_row, 2'(col)};
                if (sq_row == 2'd3) begin
                    sq_row  = 2'd0;
                    sq_tick = '0;
                    sq_disp = 0;
                    if (sq_pending != NO_KEY) begin
                        for (i = DIGITS - 1; i > 0; i--)
                            sq_store[i] = sq_store[i-1];
                        sq_store[0]   = sq_pending;
                        key           = sq_pending;
                        res.key_event = 1'b1;
                        sq_phase      = (hold_cfg == 16'd0) ? SEQ_SHOW : SEQ_HOLD;
                    end else begin
                        sq_phase = SEQ_SHOW;
                    end
                    sq_pending = NO_KEY;
                end else begin
                    sq_row++;
                end
            end
        endcase
        res.row_drive    = ~(4'b0001 << sq_row);
        res.segments     = sq_seg;
        res.digit_select = sq_sel;
        res.key_code     = key;
        return res;
    endfunction

    // Column lines seen while the given row is driven low.
    function automatic logic [3:0] sense_columns(input t_pad_beat p, input logic [1:0] row);
        logic [3:0] cols;
        cols = 4'hF;
        if (p.raw)
            return p.bits;
        if (p.key_a != NO_KEY && p.key_a[3:2] == row)
            cols[p.key_a[1:0]] = 1'b0;
        if (p.key_b != NO_KEY && p.key_b[3:2] == row)
            cols[p.key_b[1:0]] = 1'b0;
        return cols;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("MISMATCH %s: got 0x%0h, want 0x%0h (result beat %0d)",
                 what, got, want, results);
    endtask

    task automatic push_hold(input logic [4:0] a, input logic [4:0] b, input int n);
        t_pad_beat p;
        p.key_a = a;
        p.key_b = b;
        p.raw   = 1'b0;
        p.bits  = 4'hF;
        repeat (n) pad_queue.push_back(p);
    endtask

    task automatic push_raw(input logic [3:0] bits, input int n);
        t_pad_beat p;
        p.key_a = NO_KEY;
        p.key_b = NO_KEY;
        p.raw   = 1'b1;
        p.bits  = bits;
        repeat (n) pad_queue.push_back(p);
    endtask

    // Mostly clean presses; some two-key presses, releases and line noise.
    task automatic add_press();
        int         kind;
        int         len;
        logic [4:0] a;
        logic [4:0] b;
        kind = $urandom_range(0, 99);
        len  = $urandom_range(1, 12);
        a    = 5'($urandom_range(0, 15));
        b    = 5'($urandom_range(0, 15));
        if (kind < 60)
            push_hold(a, NO_KEY, len);
        else if (kind < 72)
            push_hold(a, b, len);
        else if (kind < 86)
            push_hold(NO_KEY, NO_KEY, len);
        else
            repeat (len) push_raw(4'($urandom_range(0, 15)), 1);
    endtask

    task automatic run_random(input int target);
        int start;
        start = scan_beats;
        while (scan_beats - start < target) begin
            if (pad_queue.size() < 8)
                add_press();
            else
                @(posedge i_clk);
        end
    endtask

    task automatic wait_quiet();
        do
            @(posedge i_clk);
        while (pad_queue.size() != 0 || in_if.valid || expected_beats.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [15:0] hold, input logic [7:0] digit);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HOLD_TICKS;
        cfg_data  <= hold;
        @(posedge i_clk);
        cfg_index <= REG_DIGIT_TICKS;
        cfg_data  <= {8'd0, digit};
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        hold_cfg  = hold;
        digit_cfg = digit;
    endtask

    // Column driver: one beat per queued pad state, idle gaps between beats.
    always @(posedge i_clk) begin : drive_columns
        bit        sent;
        t_pad_beat pad_now;
        sent = 1'b0;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
            send_gap    = 0;
            hold_cfg    = HOLD_TICKS_RST;
            digit_cfg   = DIGIT_TICKS_RST;
            sq_phase    = SEQ_SCAN;
            sq_row      = 2'd0;
            sq_disp     = 0;
            sq_pending  = NO_KEY;
            foreach (sq_store[k])
                sq_store[k] = NO_KEY;
            sq_tick     = '0;
            sq_seg      = 8'd0;
            sq_sel      = SEL_BLANK;
        end else begin
            if (in_if.valid && in_if.ready) begin
                if (sq_phase == SEQ_SCAN)
                    scan_beats++;
                expected_beats.push_back(advance_sequencer(in_if.data.column_bits));
                beats_in++;
                sent = 1'b1;
                if (beats_in % 40 == 0)
                    steady_in = ($urandom_range(0, 3) == 0);
                send_gap = (fast || steady_in) ? 0 : $urandom_range(0, 10);
            end
            if (!in_if.valid || sent) begin
                if (send_gap > 0) begin
                    send_gap--;
                    if (sent)
                        in_if.valid <= 1'b0;
                end else if (pad_queue.size() != 0) begin
                    pad_now = pad_queue.pop_front();
                    // sample follows the row the block drives for the next tick
                    in_if.data.column_bits <= sense_columns(pad_now, sq_row);
                    in_if.valid            <= 1'b1;
                end else if (sent) begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each beat, then stall the result side at random.
    always @(posedge i_clk) begin : check_results
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_off     = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = out_if.data;
                results++;
                if (got.key_event)
                    key_events++;
                if (expected_beats.size() == 0) begin
                    flag_mismatch("result with nothing pending", 64'(got), 64'd0);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.row_drive !== want.row_drive)
                        flag_mismatch("row_drive", 64'(got.row_drive),
                                      64'(want.row_drive));
                    if (got.segments !== want.segments)
                        flag_mismatch("segments", 64'(got.segments),
                                      64'(want.segments));
                    if (got.digit_select !== want.digit_select)
                        flag_mismatch("digit_select", 64'(got.digit_select),
                                      64'(want.digit_select));
                    if (got.key_code !== want.key_code)
                        flag_mismatch("key_code", 64'(got.key_code),
                                      64'(want.key_code));
                    if (got.key_event !== want.key_event)
                        flag_mismatch("key_event", 64'(got.key_event),
                                      64'(want.key_event));
                end
                if (results % 40 == 0)
                    steady_out = ($urandom_range(0, 3) == 0);
                hold_off = (fast || steady_out) ? 0 : $urandom_range(0, 10);
                // long hold-off once so the result register fills and input backs up
                if (results == PRESSURE_AT)
                    hold_off = PRESSURE_LEN;
            end
            if (hold_off > 0) begin
                hold_off--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        i_rst_n      <= 1'b0;
        fast         = 1'b0;
        steady_in    = 1'b0;
        steady_out   = 1'b0;
        scan_beats   = 0;
        beats_in     = 0;
        results      = 0;
        key_events   = 0;
        mismatches   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: a blank round, then a key that starts the long hold
        push_hold(NO_KEY, NO_KEY, 8);
        push_hold(5'd3, NO_KEY, 4);
        push_hold(NO_KEY, NO_KEY, 20);
        wait_quiet();

        // widest hold and digit time, each cut short by the next register write
        fast = 1'b1;
        load_regs(16'hFFFF, 8'd255);
        push_hold(NO_KEY, NO_KEY, 20);
        wait_quiet();
        load_regs(16'd1, 8'd255);
        push_hold(NO_KEY, NO_KEY, 31);
        wait_quiet();
        fast = 1'b0;

        // directed: extremes, single columns, last row wins, same-row ghost
        load_regs(16'd0, 8'd1);
        // finish the digit sweep so the patterns start at row 0
        push_hold(NO_KEY, NO_KEY, 4);
        push_raw(4'h0, 4);
        push_raw(4'hF, 4);
        push_raw(4'hE, 1);
        push_raw(4'hD, 1);
        push_raw(4'hB, 1);
        push_raw(4'h7, 1);
        push_hold(5'd0, NO_KEY, 8);
        push_hold(5'd5, NO_KEY, 8);
        push_hold(5'd10, NO_KEY, 8);
        push_hold(5'd15, NO_KEY, 8);
        push_hold(5'd1, 5'd14, 8);
        push_hold(5'd4, 5'd6, 8);
        push_hold(5'd9, NO_KEY, 8);
        wait_quiet();

        // zero digit time acts as one tick
        load_regs(16'd0, 8'd0);
        run_random(50);
        wait_quiet();

        repeat (3) begin
            load_regs(16'($urandom_range(1, 20)), 8'($urandom_range(1, 6)));
            run_random(12);
            wait_quiet();
        end

        load_regs(16'd3, 8'd2);
        run_random(100);
        wait_quiet();
        repeat (4) @(posedge i_clk);

        if (expected_beats.size() != 0)
            flag_mismatch("results never produced", 64'(expected_beats.size()), 64'd0);
        $display("Ran %0d column beats (%0d in scan rows), %0d result beats, %0d keys taken.",
                 beats_in, scan_beats, results, key_events);
        $display("Register values from zero to full width loaded mid-sequence; %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
